// ----- rtl/nlc_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants of the n-gram language classifier.
// Holds the n-gram patterns, the language profiles and the back-end state type.
package nlc_pkg;

  localparam int NGRAMS      = 10;
  localparam int NUM_CNT     = 2 * NGRAMS;
  localparam int IDX_W       = $clog2(NUM_CNT);
  localparam int DIST_W      = 38;
  localparam int PROF_W      = 9;
  localparam int QUEUE_DEPTH = 2;

  // bigrams: th he in er an en ch de ei te
  localparam logic [7:0] BI_A [NGRAMS] = '{"t", "h", "i", "e", "a", "e", "c", "d", "e", "t"};
  localparam logic [7:0] BI_B [NGRAMS] = '{"h", "e", "n", "r", "n", "n", "h", "e", "i", "e"};

  // trigrams: the and ing ent ion der sch ich nde die
  localparam logic [7:0] TRI_A [NGRAMS] = '{"t", "a", "i", "e", "i", "d", "s", "i", "n", "d"};
  localparam logic [7:0] TRI_B [NGRAMS] = '{"h", "n", "n", "n", "o", "e", "c", "c", "d", "i"};
  localparam logic [7:0] TRI_C [NGRAMS] = '{"e", "d", "g", "t", "n", "r", "h", "h", "e", "e"};

  // Profiles in hundredths, bigrams first, then trigrams.
  localparam logic [PROF_W-1:0] ENG_PROF [NUM_CNT] = '{
    9'd271, 9'd233, 9'd203, 9'd178, 9'd161, 9'd113, 9'd1, 9'd1, 9'd1, 9'd1,
    9'd181, 9'd73,  9'd72,  9'd42,  9'd42,  9'd1,   9'd1, 9'd1, 9'd1, 9'd1
  };
  localparam logic [PROF_W-1:0] GER_PROF [NUM_CNT] = '{
    9'd1,   9'd89,  9'd171, 9'd390, 9'd107, 9'd361, 9'd236, 9'd231, 9'd198, 9'd198,
    9'd1,   9'd1,   9'd1,   9'd1,   9'd1,   9'd104, 9'd76,  9'd75,  9'd72,  9'd62
  };

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_RUN,
    BK_DRAIN
  } back_state_e;

endpackage

// ----- rtl/nlc_front.sv -----
`timescale 1ns / 1ps
// Front end: takes text bytes, tracks the last two bytes and the n-gram counters.
// Depends on nlc_pkg for patterns and counter layout.
module nlc_front import nlc_pkg::*; #(
  parameter int COUNT_BITS = 10
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  accept_i,
  input  logic [7:0]                            text_byte_i,
  input  logic                                  last_i,
  output logic                                  push_o,
  output logic [NUM_CNT-1:0][COUNT_BITS-1:0]    push_data_o
);

  logic [7:0]                         prev1_q, prev1_d;
  logic [7:0]                         prev2_q, prev2_d;
  logic [NUM_CNT-1:0][COUNT_BITS-1:0] cnt_q, cnt_d, cnt_upd;
  logic [NUM_CNT-1:0]                 hit;

  always_comb begin
    for (int i = 0; i < NGRAMS; i++) begin
      hit[i] = (prev1_q == BI_A[i]) && (text_byte_i == BI_B[i]);
      hit[NGRAMS + i] = (prev2_q == TRI_A[i]) && (prev1_q == TRI_B[i]) &&
                        (text_byte_i == TRI_C[i]);
    end
    for (int i = 0; i < NUM_CNT; i++) begin
      cnt_upd[i] = cnt_q[i];
      // saturate at the top of the range
      if (hit[i] && !(&cnt_q[i])) begin
        cnt_upd[i] = cnt_q[i] + 1'b1;
      end
    end
  end

  always_comb begin
    prev1_d = prev1_q;
    prev2_d = prev2_q;
    cnt_d   = cnt_q;
    if (accept_i) begin
      if (last_i) begin
        // start a fresh text after the final byte
        prev1_d = '0;
        prev2_d = '0;
        cnt_d   = '0;
      end else begin
        prev1_d = text_byte_i;
        prev2_d = prev1_q;
        cnt_d   = cnt_upd;
      end
    end
  end

  assign push_o      = accept_i && last_i;
  assign push_data_o = cnt_upd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev1_q <= '0;
      prev2_q <= '0;
      cnt_q   <= '0;
    end else begin
      prev1_q <= prev1_d;
      prev2_q <= prev2_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

// ----- rtl/nlc_queue.sv -----
`timescale 1ns / 1ps
// Short queue of counter snapshots between front and back end.
// Depends on nlc_pkg for the default depth, QUEUE_DEPTH.
module nlc_queue import nlc_pkg::*; #(
  parameter int Width = 200,
  parameter int Depth = QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] push_data_i,
  input  logic             pop_i,
  output logic [Width-1:0] head_o,
  output logic             full_o,
  output logic             not_empty_o
);

  localparam int PTR_W = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CNT_W = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] fill_q, fill_d;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    if (p == PTR_W'(Depth - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (push_i) begin
      wr_ptr_d = ptr_inc(wr_ptr_q);
    end
    if (pop_i) begin
      rd_ptr_d = ptr_inc(rd_ptr_q);
    end
    unique case ({push_i, pop_i})
      2'b10:   fill_d = fill_q + 1'b1;
      2'b01:   fill_d = fill_q - 1'b1;
      default: fill_d = fill_q;
    endcase
  end

  assign head_o      = mem_q[rd_ptr_q];
  assign full_o      = (fill_q == CNT_W'(Depth));
  assign not_empty_o = (fill_q != '0);

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

endmodule

// ----- rtl/nlc_back.sv -----
`timescale 1ns / 1ps
// Back end: walks the twenty counters of one snapshot and sums squared distances.
// Depends on nlc_pkg for profiles, widths and the state type.
module nlc_back import nlc_pkg::*; #(
  parameter int COUNT_BITS = 10
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               not_empty_i,
  input  logic [NUM_CNT-1:0][COUNT_BITS-1:0] head_i,
  output logic                               pop_o,
  output logic                               done_o,
  output logic                               is_german_o,
  output logic [DIST_W-1:0]                  dist_english_sq_o,
  output logic [DIST_W-1:0]                  dist_german_sq_o
);

  localparam int D_W   = COUNT_BITS + 7;
  localparam int SQ_W  = 2 * D_W;
  localparam int SUM_W = SQ_W + 5;
  localparam int ACC_W = (SUM_W > DIST_W) ? SUM_W : DIST_W;

  back_state_e       state_q, state_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic              issue;
  logic              s1_v_q, s2_v_q;
  logic [D_W-1:0]    scaled, prof_e, prof_g, ad_e, ad_g;
  logic [D_W-1:0]    ad_e_q, ad_g_q;
  logic [SQ_W-1:0]   sq_e_q, sq_g_q;
  logic [ACC_W-1:0]  acc_e_q, acc_e_d, acc_g_q, acc_g_d;
  logic              clear_acc;
  logic              done_d;

  // stage 0: scale the selected count and take absolute differences
  always_comb begin
    scaled = D_W'(head_i[idx_q]) * D_W'(100);
    prof_e = D_W'(ENG_PROF[idx_q]);
    prof_g = D_W'(GER_PROF[idx_q]);
    ad_e   = (scaled >= prof_e) ? (scaled - prof_e) : (prof_e - scaled);
    ad_g   = (scaled >= prof_g) ? (scaled - prof_g) : (prof_g - scaled);
  end

  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    issue     = 1'b0;
    clear_acc = 1'b0;
    pop_o     = 1'b0;
    done_d    = 1'b0;
    unique case (state_q)
      BK_IDLE: begin
        if (not_empty_i) begin
          clear_acc = 1'b1;
          idx_d     = '0;
          state_d   = BK_RUN;
        end
      end
      BK_RUN: begin
        issue = 1'b1;
        idx_d = idx_q + 1'b1;
        if (idx_q == IDX_W'(NUM_CNT - 1)) begin
          state_d = BK_DRAIN;
        end
      end
      BK_DRAIN: begin
        // sums are final once the pipeline is empty
        if (!s1_v_q && !s2_v_q) begin
          done_d  = 1'b1;
          pop_o   = 1'b1;
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_comb begin
    acc_e_d = acc_e_q;
    acc_g_d = acc_g_q;
    if (clear_acc) begin
      acc_e_d = '0;
      acc_g_d = '0;
    end else if (s2_v_q) begin
      acc_e_d = acc_e_q + ACC_W'(sq_e_q);
      acc_g_d = acc_g_q + ACC_W'(sq_g_q);
    end
  end

  always_ff @(posedge clk_i) begin
    ad_e_q  <= ad_e;
    ad_g_q  <= ad_g;
    sq_e_q  <= ad_e_q * ad_e_q;
    sq_g_q  <= ad_g_q * ad_g_q;
    acc_e_q <= acc_e_d;
    acc_g_q <= acc_g_d;
    if (done_d) begin
      is_german_o       <= !(acc_e_q < acc_g_q);
      dist_english_sq_o <= acc_e_q[DIST_W-1:0];
      dist_german_sq_o  <= acc_g_q[DIST_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
      idx_q   <= '0;
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      done_o  <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      s1_v_q  <= issue;
      s2_v_q  <= s1_v_q;
      done_o  <= done_d;
    end
  end

endmodule

// ----- rtl/ngram_language_classifier_top.sv -----
`timescale 1ns / 1ps
// N-gram language classifier, English versus German, top level.
// Throughput: one text byte per cycle while busy is low; the back end takes one
// text at a time and walks its twenty counters one per cycle through the squarer.
// busy rises while the snapshot queue holds two texts.
// Reset clears counters, previous bytes and the queue; done_o is a one-cycle strobe.
module ngram_language_classifier_top import nlc_pkg::*; #(
  parameter int COUNT_BITS = 10
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic [7:0]        text_byte_i,
  input  logic              last_i,
  output logic              done_o,
  output logic              is_german_o,
  output logic [DIST_W-1:0] dist_english_sq_o,
  output logic [DIST_W-1:0] dist_german_sq_o
);

  localparam int SNAP_W = NUM_CNT * COUNT_BITS;

  logic                               accept;
  logic                               push;
  logic [NUM_CNT-1:0][COUNT_BITS-1:0] push_data;
  logic [NUM_CNT-1:0][COUNT_BITS-1:0] head;
  logic                               pop;
  logic                               full;
  logic                               not_empty;

  // A transfer happens whenever start is high and the snapshot queue has room.
  assign busy   = full;
  assign accept = start && !busy;

  // Front end: count n-grams, push a counter snapshot on the final byte.
  nlc_front #(
    .COUNT_BITS (COUNT_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .text_byte_i (text_byte_i),
    .last_i      (last_i),
    .push_o      (push),
    .push_data_o (push_data)
  );

  // Hold finished texts until the back end is free.
  nlc_queue #(
    .Width (SNAP_W),
    .Depth (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .head_o      (head),
    .full_o      (full),
    .not_empty_o (not_empty)
  );

  // Back end: sum squared distances and strobe out the verdict.
  nlc_back #(
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .not_empty_i       (not_empty),
    .head_i            (head),
    .pop_o             (pop),
    .done_o            (done_o),
    .is_german_o       (is_german_o),
    .dist_english_sq_o (dist_english_sq_o),
    .dist_german_sq_o  (dist_german_sq_o)
  );

endmodule
